// ===== rtl/core/asw_pkg.sv =====
// ----------------------------------------------------------------------------
// asw_pkg
// Shared types and constants for the asynchronous serial word receiver.
// ----------------------------------------------------------------------------
package asw_pkg;

    // Fixed field widths
    localparam int WORD_BITS_W  = 4;
    localparam int STEP_W       = 16;
    localparam int STEP_FRAC    = 16;
    localparam int MAX_WORD     = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int CNT_W        = 4;

    // Default fractional bits of the bit phase
    localparam int DEF_FRAC_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BITS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd1;

    // Reset values of the registers
    localparam logic [WORD_BITS_W-1:0] RST_WORD_BITS  = 4'd5;
    localparam logic [STEP_W-1:0]      RST_PHASE_STEP = 16'd62;

    // Configuration as seen by the frame engine
    typedef struct packed {
        logic [WORD_BITS_W-1:0] word_bits;
        logic [STEP_W-1:0]      phase_step;
    } t_cfg;

    // Effective word width: 0 acts as 1, above 8 acts as 8
    function automatic logic [WORD_BITS_W-1:0] eff_width(
        input logic [WORD_BITS_W-1:0] wb
    );
        logic [WORD_BITS_W-1:0] w;
        w = wb;
        if (wb == '0) begin
            w = WORD_BITS_W'(1);
        end else if (wb > WORD_BITS_W'(MAX_WORD)) begin
            w = WORD_BITS_W'(MAX_WORD);
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/asw_frame.sv =====
// ----------------------------------------------------------------------------
// asw_frame
// Frame engine: bit phase accumulator, bit counter and shift word. Takes one
// line sample per cycle when advanced and flags a finished character.
// ----------------------------------------------------------------------------
module asw_frame #(
    parameter int FRAC_BITS = asw_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_sample,
    input  asw_pkg::t_cfg                 i_cfg,
    output logic                          o_emit,
    output logic [asw_pkg::MAX_WORD-1:0]  o_word
);
    import asw_pkg::*;

    // Phase spans minus one half to below two bits
    localparam int PW  = FRAC_BITS + 2;
    localparam int SHL = (FRAC_BITS >= STEP_FRAC) ? (FRAC_BITS - STEP_FRAC) : 0;
    localparam int SHR = (FRAC_BITS >= STEP_FRAC) ? 0 : (STEP_FRAC - FRAC_BITS);
    localparam logic signed [PW-1:0] ONE   = PW'(1) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] START = -(PW'(1) <<< (FRAC_BITS - 1));

    logic                     r_idle,  n_idle;
    logic signed [PW-1:0]     r_phase, n_phase;
    logic [CNT_W-1:0]         r_bits,  n_bits;
    logic [MAX_WORD-1:0]      r_word,  n_word;

    logic signed [PW-1:0]     step_s;
    logic signed [PW-1:0]     sum;
    logic [WORD_BITS_W-1:0]   w;
    logic [MAX_WORD-1:0]      top_bit;

    // Rescale step to the phase format
    assign step_s = (FRAC_BITS >= STEP_FRAC) ? (PW'(i_cfg.phase_step) << SHL)
                                             : PW'(i_cfg.phase_step >> SHR);
    assign sum     = r_phase + step_s;
    assign w       = eff_width(i_cfg.word_bits);
    assign top_bit = MAX_WORD'(1) << (w - WORD_BITS_W'(1));

    // Next state for one sample
    always_comb begin
        n_idle  = r_idle;
        n_phase = r_phase;
        n_bits  = r_bits;
        n_word  = r_word;
        o_emit  = 1'b0;
        if (i_adv) begin
            if (r_idle) begin
                if (!i_sample) begin
                    n_idle  = 1'b0;
                    n_phase = START;
                    n_bits  = '0;
                    n_word  = '0;
                end
            end else if (sum < ONE) begin
                n_phase = sum;
            end else begin
                n_phase = sum - ONE;
                if ((r_bits >= CNT_W'(w)) && i_sample) begin
                    // stop bit: character complete
                    o_emit = 1'b1;
                    n_idle = 1'b1;
                end else begin
                    n_word = (r_word >> 1) + (i_sample ? top_bit : '0);
                    if (r_bits < CNT_W'(w)) begin
                        n_bits = r_bits + CNT_W'(1);
                    end
                end
            end
        end
    end

    assign o_word = r_word;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle  <= 1'b1;
            r_phase <= '0;
            r_bits  <= '0;
            r_word  <= '0;
        end else begin
            r_idle  <= n_idle;
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_word  <= n_word;
        end
    end

endmodule

// ===== rtl/core/async_serial_word_receiver.sv =====
// ----------------------------------------------------------------------------
// async_serial_word_receiver
// Recovers start/stop framed characters from hard-decision line samples.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis): one line sample per transfer, tdata bit 0.
//   Master stream (m_axis): one received character per transfer.
//   Config channel: index 0 = word_bits, 1 = phase_step; always ready; the user
//   must write only while no sample or character is in flight (not enforced).
// Path: a sample waits in the input register until the frame engine takes it,
//   which it does while the output register is free; a character is offered
//   on m_axis from the edge at which the engine takes its stop sample.
// Throughput: one sample per cycle while the output is not blocked, set by the
//   phase update of the frame engine.
// Reset: the receiver waits for a start bit, registers return to
//   word_bits = 5 and phase_step = 62, both streams empty.
// Stall: while a character waits on m_axis the input register still takes
//   one sample; tready drops only when that register is also full and the
//   output is blocked.
// ----------------------------------------------------------------------------
module async_serial_word_receiver #(
    parameter int FRAC_BITS = asw_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [asw_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [0] line_sample
    // character stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [asw_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [7:0] word
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [asw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [asw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import asw_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_in_valid;
    logic                 r_in_sample;
    logic                 r_out_valid;
    logic [MAX_WORD-1:0]  r_out_word;

    logic                 out_free;
    logic                 adv;
    logic                 emit;
    logic [MAX_WORD-1:0]  word;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_word);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.word_bits  <= RST_WORD_BITS;
            r_cfg.phase_step <= RST_PHASE_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WORD_BITS:  r_cfg.word_bits  <= i_cfg_data[WORD_BITS_W-1:0];
                CFG_PHASE_STEP: r_cfg.phase_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_sample <= s_axis_tdata[0];
        end
    end

    // Frame engine
    asw_frame #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_sample (r_in_sample),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_word   (word)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= word;
        end
    end

    // A finished character always lands in the output register
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("character lost on emit");

    // Emit only happens when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (adv && out_free))
        else $error("emit without free output register");

    // A held sample is kept while the output is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_sample)))
        else $error("held sample dropped");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the asynchronous serial word receiver. Line samples
// are streamed in as start/stop frames built at a chosen bit rate, plus noise
// and damaged frames. Each expected character comes from a bit-accurate mirror
// of the frame engine or a directed row; m_axis transfers are checked in order.
// ----------------------------------------------------------------------------
module testbench;

    import asw_pkg::*;

    // Run limits
    localparam int RAND_SAMPLES = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 4;

    // One bit period in the phase accumulator (16 fractional bits)
    localparam logic signed [17:0] ONE_BIT  = 18'sd65536;
    localparam logic signed [17:0] HALF_BIT = 18'sd32768;

    // One directed frame: register settings, line bits (first sent in bit 0)
    // and, where obvious, the character that must come out
    typedef struct {
        logic [WORD_BITS_W-1:0] wb;
        logic [STEP_W-1:0]      step;
        logic [STEP_W-1:0]      tx_step;
        logic [15:0]            line;
        int                     nbits;
        int                     tail;
        bit                     known;
        logic [7:0]             word;
    } t_frame_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;    // [0] line_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;          // [7:0] word
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_WORD_BITS;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // Mirror of the receiver state and registers
    logic                   rx_idle      = 1'b1;
    logic signed [17:0]     rx_phase     = '0;
    logic [CNT_W-1:0]       rx_taken     = '0;
    logic [7:0]             rx_shift     = '0;
    logic [WORD_BITS_W-1:0] rx_word_bits = RST_WORD_BITS;
    logic [STEP_W-1:0]      rx_step      = RST_PHASE_STEP;

    logic [7:0]             pending_words[$];
    logic [7:0]             want_word;
    t_frame_row             plan[$];
    bit                     typed_valid = 1'b0;
    logic [7:0]             typed_word  = '0;
    bit                     calm        = 1'b0;
    bit                     hold_req    = 1'b0;
    int                     samples_sent = 0;
    int                     fails        = 0;
    int                     idle_cycles  = 0;

    async_serial_word_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Width actually used: zero counts as one, above eight as eight
    function automatic logic [WORD_BITS_W-1:0] width_of(input logic [WORD_BITS_W-1:0] wb);
        if (wb == '0)
            return WORD_BITS_W'(1);
        if (wb > WORD_BITS_W'(8))
            return WORD_BITS_W'(8);
        return wb;
    endfunction

    // Start bit, w data bits LSB first, one stop bit
    function automatic logic [15:0] framed(input logic [7:0] data, input int w);
        logic [15:0] mask;
        mask = (16'd1 << w) - 16'd1;
        return (16'd1 << (w + 1)) | (({8'd0, data} & mask) << 1);
    endfunction

    // Frame engine mirror: returns 1 when the sample completes a character
    function automatic bit clock_in_level(input logic mark, output logic [7:0] word);
        logic [WORD_BITS_W-1:0] w;
        word = '0;
        if (rx_idle) begin
            // a space while idle opens a frame, phase at minus half a bit
            if (!mark) begin
                rx_idle  = 1'b0;
                rx_phase = -HALF_BIT;
                rx_taken = '0;
                rx_shift = '0;
            end
            return 1'b0;
        end
        rx_phase = rx_phase + $signed({2'b00, rx_step});
        if (rx_phase < ONE_BIT)
            return 1'b0;
        rx_phase = rx_phase - ONE_BIT;
        w = width_of(rx_word_bits);
        // stop bit once the count is full
        if (rx_taken >= CNT_W'(w) && mark) begin
            word    = rx_shift;
            rx_idle = 1'b1;
            return 1'b1;
        end
        rx_shift = rx_shift >> 1;
        if (mark)
            rx_shift = rx_shift + (8'd1 << (w - 1'b1));
        if (rx_taken < CNT_W'(w))
            rx_taken = rx_taken + 1'b1;
        return 1'b0;
    endfunction

    // One sample transfer, with an occasional gap before it
    task automatic push_level(input logic level);
        logic [7:0] word;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, level};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        if (clock_in_level(level, word)) begin
            if (typed_valid) begin
                pending_words.push_back(typed_word);
                typed_valid = 1'b0;
            end else begin
                pending_words.push_back(word);
            end
        end
        @(negedge i_clk);
    endtask

    // Sample a line waveform at the transmitter's own rate, then idle marks
    task automatic send_line(input logic [15:0] line, input int nbits,
                             input logic [STEP_W-1:0] tx_step, input int tail);
        longint unsigned acc;
        int              idx;
        acc = 0;
        idx = 0;
        while (idx < nbits) begin
            push_level(line[idx]);
            acc = acc + tx_step;
            idx = int'(acc >> 16);
        end
        repeat (tail) push_level(1'b1);
    endtask

    // Stop sending and wait for every character still owed
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers once the receiver has drained
    task automatic program_regs(input logic [WORD_BITS_W-1:0] wb,
                                input logic [STEP_W-1:0] step);
        logic [CFG_DATA_W-WORD_BITS_W-1:0] junk;
        int                                r;
        junk = (CFG_DATA_W-WORD_BITS_W)'($urandom);
        settle();
        for (r = 0; r < 2; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (r == 0) ? CFG_WORD_BITS : CFG_PHASE_STEP;
            i_cfg_data  <= (r == 0) ? {junk, wb} : step;
            do @(posedge i_clk); while (!o_cfg_ready);
            if (r == 0)
                rx_word_bits = wb;
            else
                rx_step = step;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Character checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected transfer: word %02h", m_axis_tdata);
                fails++;
            end else begin
                want_word = pending_words.pop_front();
                if (m_axis_tdata !== want_word) begin
                    $error("word mismatch: expected %02h, actual %02h",
                           want_word, m_axis_tdata);
                    fails++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Character sink: random ready bursts, one long hold-off on request
    initial begin : sink
        int burst;
        bit rdy;
        burst = 0;
        rdy   = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else if (burst == 0) begin
                rdy   = ($urandom_range(0, 3) != 0);
                burst = rdy ? $urandom_range(1, 30) : $urandom_range(1, 15);
                m_axis_tready <= rdy;
            end else begin
                burst--;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int                     rand_start;
        int                     done_cnt;
        int                     kind;
        int                     flip;
        int                     w;
        bit                     hold_issued;
        bit                     pause_issued;
        logic [7:0]             data;
        logic [15:0]            line;
        logic [STEP_W-1:0]      tx;
        logic [WORD_BITS_W-1:0] wb;
        logic [STEP_W-1:0]      step;

        hold_issued  = 1'b0;
        pause_issued = 1'b0;

        // wb, rx step, tx step, line, bits, tail marks, typed, word
        // reset width of five bits, four samples per bit
        plan.push_back('{4'd5, 16'd16384, 16'd16384, framed(8'h15, 5), 7, 2, 1'b1, 8'h15});
        // full width extremes
        plan.push_back('{4'd8, 16'd32768, 16'd32768, framed(8'h00, 8), 10, 2, 1'b1, 8'h00});
        plan.push_back('{4'd8, 16'd32768, 16'd32768, framed(8'hFF, 8), 10, 2, 1'b1, 8'hFF});
        plan.push_back('{4'd8, 16'd65535, 16'd65535, framed(8'hA5, 8), 10, 2, 1'b1, 8'hA5});
        // single bit words, and width zero acting as one
        plan.push_back('{4'd1, 16'd16384, 16'd16384, framed(8'h01, 1), 3, 1, 1'b1, 8'h01});
        plan.push_back('{4'd1, 16'd16384, 16'd16384, framed(8'h00, 1), 3, 1, 1'b1, 8'h00});
        plan.push_back('{4'd0, 16'd16384, 16'd16384, framed(8'h01, 1), 3, 1, 1'b1, 8'h01});
        // width above eight acting as eight
        plan.push_back('{4'd15, 16'd32768, 16'd32768, framed(8'h5A, 8), 10, 2, 1'b1, 8'h5A});
        plan.push_back('{4'd9, 16'd32768, 16'd32768, framed(8'hC3, 8), 10, 2, 1'b1, 8'hC3});
        // low stop bits keep shifting until a high one arrives
        plan.push_back('{4'd8, 16'd32768, 16'd32768, 16'h0902, 12, 2, 1'b0, 8'h00});
        // width narrowed, then widened, mid-frame
        plan.push_back('{4'd8, 16'd16384, 16'd16384, 16'h000A, 4, 0, 1'b0, 8'h00});
        plan.push_back('{4'd3, 16'd16384, 16'd16384, 16'h0002, 2, 2, 1'b0, 8'h00});
        plan.push_back('{4'd6, 16'd16384, 16'd16384, 16'h0026, 6, 0, 1'b0, 8'h00});
        plan.push_back('{4'd2, 16'd16384, 16'd16384, 16'h0007, 3, 2, 1'b0, 8'h00});
        // zero step stalls the frame until the step is raised
        plan.push_back('{4'd8, 16'd0, 16'd16384, framed(8'h3C, 8), 10, 0, 1'b0, 8'h00});
        plan.push_back('{4'd4, 16'd8192, 16'd8192, 16'h003F, 6, 2, 1'b0, 8'h00});
        // slowest step, then fastest step mid-frame
        plan.push_back('{4'd7, 16'd1, 16'd16384, 16'h0006, 3, 0, 1'b0, 8'h00});
        plan.push_back('{4'd7, 16'd65535, 16'd65535, 16'h01FF, 9, 2, 1'b0, 8'h00});
        // transmitter slightly off rate, then an odd ratio
        plan.push_back('{4'd8, 16'd16384, 16'd18000, framed(8'h6D, 8), 10, 3, 1'b0, 8'h00});
        plan.push_back('{4'd8, 16'd43690, 16'd43690, framed(8'h3E, 8), 10, 2, 1'b0, 8'h00});
        // a one-sample glitch opens a frame of marks
        plan.push_back('{4'd8, 16'd32768, 16'd65535, 16'h03FE, 10, 12, 1'b0, 8'h00});

        // hold synchronous reset, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames
        foreach (plan[r]) begin
            if (plan[r].wb != rx_word_bits || plan[r].step != rx_step)
                program_regs(plan[r].wb, plan[r].step);
            typed_valid = plan[r].known;
            typed_word  = plan[r].word;
            send_line(plan[r].line, plan[r].nbits, plan[r].tx_step, plan[r].tail);
            typed_valid = 1'b0;
        end

        // Random frames, damaged frames, noise and register changes
        rand_start = samples_sent;
        while ((samples_sent - rand_start) < RAND_SAMPLES) begin
            done_cnt = samples_sent - rand_start;
            if (done_cnt > RAND_SAMPLES * 4 / 5)
                calm = 1'b1;
            if (!hold_issued && done_cnt > 200) begin
                hold_req    = 1'b1;
                hold_issued = 1'b1;
            end
            if (!pause_issued && done_cnt > 700) begin
                settle();
                pause_issued = 1'b1;
            end
            kind = $urandom_range(0, 19);
            w    = int'(width_of(rx_word_bits));
            data = 8'($urandom);
            tx   = rx_step;
            if ($urandom_range(0, 3) == 0)
                tx = rx_step - STEP_W'($urandom_range(0, rx_step / 32));
            if (kind < 2 && !calm) begin
                wb   = ($urandom_range(0, 4) == 0) ? WORD_BITS_W'($urandom_range(0, 15))
                                                   : WORD_BITS_W'($urandom_range(1, 8));
                step = ($urandom_range(0, 7) == 0) ? STEP_W'($urandom_range(8192, 21845))
                                                   : STEP_W'($urandom_range(21846, 65535));
                program_regs(wb, step);
            end else if (kind < 4) begin
                repeat ($urandom_range(1, 12)) push_level(1'($urandom_range(0, 1)));
            end else if (kind < 6) begin
                // one bit flipped, possibly cut short
                line       = framed(data, w);
                flip       = $urandom_range(0, w + 1);
                line[flip] = ~line[flip];
                send_line(line, $urandom_range(1, w + 2), tx, $urandom_range(0, 3));
            end else begin
                send_line(framed(data, w), w + 2, tx, $urandom_range(0, 4));
            end
        end

        // Drain and finish
        settle();
        repeat (6) @(negedge i_clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
